[hdl/single_wire_panel_session_engine_assert.svh]
// Assertion macros shared by the panel link RTL.
`ifndef SINGLE_WIRE_PANEL_SESSION_ENGINE_ASSERT_SVH
`define SINGLE_WIRE_PANEL_SESSION_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWPSE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWPSE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/swpse_pkg.sv]
package swpse_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_REQUEST  = 3'd2,
    PH_WAITING  = 3'd3,
    PH_RESPONSE = 3'd4,
    PH_STOPPED  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REG_BIT_PERIOD    = 2'd0,
    REG_POLL_PERIOD   = 2'd1,
    REG_TOUCH_CAPABLE = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_INFO   = 3'd0,
    KIND_BLINIT = 3'd1,
    KIND_BRIGHT = 3'd2,
    KIND_KEY    = 3'd3,
    KIND_TOUCH  = 3'd4
  } kind_t;

  localparam logic [7:0]  RQ_KEY     = 8'h30;
  localparam logic [7:0]  RQ_TOUCH   = 8'h40;
  localparam logic [7:0]  RQ_INFO    = 8'h60;
  localparam logic [7:0]  RQ_BLINIT  = 8'h7F;
  localparam logic [7:0]  CRC_INIT   = 8'hAC;
  localparam logic [7:0]  CRC_POLY   = 8'h07;
  localparam logic [7:0]  NO_TYPE    = 8'd255;
  localparam logic [7:0]  KEY_TYPE   = 8'd24;
  localparam logic [11:0] COORD_NONE = 12'hFFF;
  localparam logic [4:0]  ABSENT_AFTER = 5'd15;
  localparam logic [4:0]  SESSION_MAX  = 5'd31;
  localparam logic [5:0]  REQUEST_BITS  = 6'd16;
  localparam logic [5:0]  RESPONSE_BITS = 6'd32;

  localparam logic [23:0] BIT_PERIOD_RESET  = 24'd947;
  localparam logic [23:0] POLL_PERIOD_RESET = 24'd363636;

  typedef struct packed {
    logic [23:0] bit_period;
    logic [23:0] poll_period;
    logic        touch_capable;
  } cfg_t;

  typedef struct packed {
    logic        line_out;
    logic        line_drive;
    logic        done_valid;
    logic        crc_ok;
    logic [2:0]  request_kind;
    logic [7:0]  data0;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic        touch_down;
    logic        panel_absent;
  } result_t;

endpackage

[hdl/swpse_link.sv]
module swpse_link (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                line_in,
  input  logic                bl_req_valid,
  input  logic [6:0]          bl_level,
  input  swpse_pkg::cfg_t     cfg,
  output swpse_pkg::result_t  res
);

  `include "single_wire_panel_session_engine_assert.svh"

  swpse_pkg::phase_t phase, phase_next;
  logic [5:0]  bit_count, bit_count_next;
  logic [31:0] shift_data, shift_data_next;
  logic [7:0]  request_byte, request_byte_next;
  logic [23:0] wait_count, wait_count_next;
  logic [7:0]  panel_type, panel_type_next;
  logic        absent_flag, absent_flag_next;
  logic        bl_init_done, bl_init_done_next;
  logic        key_enabled, key_enabled_next;
  logic        touch_enabled, touch_enabled_next;
  logic [7:0]  pending_level, pending_level_next;
  logic [4:0]  session_count, session_count_next;
  logic        wire_level, wire_level_next;
  logic        wire_driven, wire_driven_next;
  logic [7:0]  crc, crc_next;

  logic [5:0]  bc_dec;
  logic [7:0]  pend_eff;
  logic        pick_valid;
  logic        pick_clears;
  logic [7:0]  pick_byte;
  logic [31:0] shift_resp;
  logic [7:0]  crc_bit;
  logic [7:0]  b0, b1, b2;
  logic        ok;
  logic [11:0] tx, ty;
  logic        tdown;
  logic [7:0]  panel_fin;
  logic [4:0]  session_inc;

  function automatic logic [7:0] crc8_byte(input logic [7:0] init, input logic [7:0] data);
    logic [7:0] c;
    c = init ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ swpse_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // A period of zero behaves as a period of one.
  function automatic logic [23:0] reload(input logic [23:0] period);
    return (period == 24'd0) ? 24'd0 : period - 24'd1;
  endfunction

  function automatic logic [2:0] kind_of(input logic [7:0] req);
    logic [2:0] k;
    if (req == swpse_pkg::RQ_INFO) k = swpse_pkg::KIND_INFO;
    else if (req == swpse_pkg::RQ_BLINIT) k = swpse_pkg::KIND_BLINIT;
    else if (req[7]) k = swpse_pkg::KIND_BRIGHT;
    else if (req == swpse_pkg::RQ_KEY) k = swpse_pkg::KIND_KEY;
    else k = swpse_pkg::KIND_TOUCH;
    return k;
  endfunction

  assign bc_dec   = bit_count - 6'd1;
  assign pend_eff = (bl_req_valid && bl_init_done) ? {1'b1, bl_level} : pending_level;

  always_comb begin
    pick_valid  = 1'b1;
    pick_clears = 1'b0;
    pick_byte   = swpse_pkg::RQ_INFO;
    if (panel_type == 8'd0) begin
      pick_byte = swpse_pkg::RQ_INFO;
    end else if (!bl_init_done) begin
      pick_byte = swpse_pkg::RQ_BLINIT;
    end else if (pend_eff != 8'd0) begin
      pick_byte   = pend_eff;
      pick_clears = 1'b1;
    end else if (key_enabled) begin
      pick_byte = swpse_pkg::RQ_KEY;
    end else if (touch_enabled) begin
      pick_byte = swpse_pkg::RQ_TOUCH;
    end else begin
      pick_valid = 1'b0;
    end
  end

  // The response CRC runs one bit per sample, so the check is ready with the last bit.
  assign shift_resp = {shift_data[30:0], line_in};
  assign crc_bit    = {crc[6:0], 1'b0} ^ ((crc[7] ^ line_in) ? swpse_pkg::CRC_POLY : 8'd0);
  assign b0 = shift_resp[31:24];
  assign b1 = shift_resp[23:16];
  assign b2 = shift_resp[15:8];
  assign ok = (crc_bit == 8'd0);
  assign tx = {b0[7:4], b1};
  assign ty = {b0[3:0], b2};
  assign tdown = (tx != swpse_pkg::COORD_NONE) && (ty != swpse_pkg::COORD_NONE);
  assign panel_fin = (ok && request_byte == swpse_pkg::RQ_INFO && b0 != swpse_pkg::NO_TYPE)
                     ? b0 : panel_type;
  assign session_inc = (session_count == swpse_pkg::SESSION_MAX) ? session_count
                       : session_count + 5'd1;

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_data_next    = shift_data;
    request_byte_next  = request_byte;
    wait_count_next    = wait_count;
    panel_type_next    = panel_type;
    absent_flag_next   = absent_flag;
    bl_init_done_next  = bl_init_done;
    key_enabled_next   = key_enabled;
    touch_enabled_next = touch_enabled;
    pending_level_next = pending_level;
    session_count_next = session_count;
    wire_level_next    = wire_level;
    wire_driven_next   = wire_driven;
    crc_next           = crc;
    res                = '0;

    if (step) begin
      pending_level_next = pend_eff;
      if (phase != swpse_pkg::PH_STOPPED) begin
        if (wait_count == 24'd0) begin
          bit_count_next = bc_dec;
          unique case (phase)
            swpse_pkg::PH_IDLE: begin
              if (pick_valid) begin
                if (pick_clears) pending_level_next = 8'd0;
                request_byte_next = pick_byte;
                shift_data_next   = {16'd0, pick_byte, crc8_byte(swpse_pkg::CRC_INIT, pick_byte)};
                wire_level_next   = 1'b0;
                wire_driven_next  = 1'b1;
                bit_count_next    = 6'd1;
                phase_next        = swpse_pkg::PH_START;
                wait_count_next   = reload(cfg.bit_period);
              end else begin
                wait_count_next = reload(cfg.poll_period);
              end
            end
            swpse_pkg::PH_START: begin
              if (bc_dec == 6'd0) begin
                bit_count_next = swpse_pkg::REQUEST_BITS;
                phase_next     = swpse_pkg::PH_REQUEST;
              end
              wait_count_next = reload(cfg.bit_period);
            end
            swpse_pkg::PH_REQUEST: begin
              wire_level_next = shift_data[bc_dec[3:0]];
              if (bc_dec == 6'd0) begin
                bit_count_next = 6'd2;
                phase_next     = swpse_pkg::PH_WAITING;
              end
              wait_count_next = reload(cfg.bit_period);
            end
            swpse_pkg::PH_WAITING: begin
              if (bc_dec == 6'd0) begin
                bit_count_next  = swpse_pkg::RESPONSE_BITS;
                shift_data_next = 32'd0;
                crc_next        = swpse_pkg::CRC_INIT;
                phase_next      = swpse_pkg::PH_RESPONSE;
              end
              // The first of the two wait bits releases the line.
              if (bc_dec == 6'd1) begin
                wire_driven_next = 1'b0;
                wire_level_next  = 1'b1;
              end
              wait_count_next = reload(cfg.bit_period);
            end
            swpse_pkg::PH_RESPONSE: begin
              shift_data_next = shift_resp;
              crc_next        = crc_bit;
              if (bc_dec == 6'd0) begin
                wire_driven_next = 1'b1;
                wire_level_next  = 1'b1;
                phase_next       = swpse_pkg::PH_IDLE;
                res.done_valid   = 1'b1;
                res.crc_ok       = ok;
                res.request_kind = kind_of(request_byte);
                res.data0        = b0;
                res.data1        = b1;
                res.data2        = b2;
                if (ok) begin
                  if (request_byte == swpse_pkg::RQ_INFO) begin
                    if (b0 != swpse_pkg::NO_TYPE) begin
                      panel_type_next = b0;
                      if (b0 == swpse_pkg::KEY_TYPE) key_enabled_next = 1'b1;
                      if (cfg.touch_capable) touch_enabled_next = 1'b1;
                    end
                  end else if (request_byte == swpse_pkg::RQ_BLINIT) begin
                    bl_init_done_next = 1'b1;
                  end else if (request_byte == swpse_pkg::RQ_TOUCH) begin
                    res.touch_x    = tx;
                    res.touch_y    = ty;
                    res.touch_down = tdown;
                  end
                end
                session_count_next = session_inc;
                if (panel_fin == 8'd0 && session_inc > swpse_pkg::ABSENT_AFTER) begin
                  absent_flag_next = 1'b1;
                  phase_next       = swpse_pkg::PH_STOPPED;
                end else begin
                  wait_count_next = reload(cfg.poll_period);
                end
              end else begin
                wait_count_next = reload(cfg.bit_period);
              end
            end
            swpse_pkg::PH_STOPPED: begin
            end
            default: begin
            end
          endcase
        end else begin
          wait_count_next = wait_count - 24'd1;
        end
      end
    end

    res.line_out     = wire_level_next;
    res.line_drive   = wire_driven_next;
    res.panel_absent = absent_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= swpse_pkg::PH_IDLE;
      bit_count     <= 6'd0;
      shift_data    <= 32'd0;
      request_byte  <= 8'd0;
      wait_count    <= 24'd0;
      panel_type    <= 8'd0;
      absent_flag   <= 1'b0;
      bl_init_done  <= 1'b0;
      key_enabled   <= 1'b0;
      touch_enabled <= 1'b0;
      pending_level <= 8'd0;
      session_count <= 5'd0;
      wire_level    <= 1'b1;
      wire_driven   <= 1'b1;
      crc           <= 8'd0;
    end else begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_data    <= shift_data_next;
      request_byte  <= request_byte_next;
      wait_count    <= wait_count_next;
      panel_type    <= panel_type_next;
      absent_flag   <= absent_flag_next;
      bl_init_done  <= bl_init_done_next;
      key_enabled   <= key_enabled_next;
      touch_enabled <= touch_enabled_next;
      pending_level <= pending_level_next;
      session_count <= session_count_next;
      wire_level    <= wire_level_next;
      wire_driven   <= wire_driven_next;
      crc           <= crc_next;
    end
  end

  `SWPSE_ASSERT_IMP(a_stop_absent, clk, rst, phase == swpse_pkg::PH_STOPPED, absent_flag, "stopped without absent flag")
  `SWPSE_ASSERT_NXT(a_absent_sticky, clk, rst, absent_flag, absent_flag, "absent flag cleared")
  `SWPSE_ASSERT_IMP(a_resp_released, clk, rst, phase == swpse_pkg::PH_RESPONSE, !wire_driven, "line driven during response")

endmodule

[hdl/single_wire_panel_session_engine.sv]
// Latency: the result of a timer tick is offered in the cycle after its transfer.
// Throughput: one tick per cycle unless stalled; a tick enters in the cycle the last result transfers.
// The output register stalls the input only when it holds a result that is stalled.
// Reset (rst, synchronous, active high) clears the link to idle with the wire driven high
// and loads the registers with bit period 947, poll period 363636 and touch enabled.
module single_wire_panel_session_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        line_in,
  input  logic        bl_req_valid,
  input  logic [6:0]  bl_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_out,
  output logic        line_drive,
  output logic        done_valid,
  output logic        crc_ok,
  output logic [2:0]  request_kind,
  output logic [7:0]  data0,
  output logic [7:0]  data1,
  output logic [7:0]  data2,
  output logic [11:0] touch_x,
  output logic [11:0] touch_y,
  output logic        touch_down,
  output logic        panel_absent
);

  `include "single_wire_panel_session_engine_assert.svh"

  swpse_pkg::cfg_t    cfg;
  swpse_pkg::result_t res_comb;
  swpse_pkg::result_t res_q;
  logic               accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period    <= swpse_pkg::BIT_PERIOD_RESET;
      cfg.poll_period   <= swpse_pkg::POLL_PERIOD_RESET;
      cfg.touch_capable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swpse_pkg::REG_BIT_PERIOD:    cfg.bit_period    <= cfg_data;
        swpse_pkg::REG_POLL_PERIOD:   cfg.poll_period   <= cfg_data;
        swpse_pkg::REG_TOUCH_CAPABLE: cfg.touch_capable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  swpse_link u_link (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .line_in      (line_in),
    .bl_req_valid (bl_req_valid),
    .bl_level     (bl_level),
    .cfg          (cfg),
    .res          (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_comb;
    end
  end

  assign line_out     = res_q.line_out;
  assign line_drive   = res_q.line_drive;
  assign done_valid   = res_q.done_valid;
  assign crc_ok       = res_q.crc_ok;
  assign request_kind = res_q.request_kind;
  assign data0        = res_q.data0;
  assign data1        = res_q.data1;
  assign data2        = res_q.data2;
  assign touch_x      = res_q.touch_x;
  assign touch_y      = res_q.touch_y;
  assign touch_down   = res_q.touch_down;
  assign panel_absent = res_q.panel_absent;

  `SWPSE_ASSERT_NXT(a_accept_fills, clk, rst, accept, out_valid, "transfer not registered")
  `SWPSE_ASSERT_NXT(a_absent_held, clk, rst, out_valid && panel_absent, panel_absent, "absent lost")
  `SWPSE_ASSERT_IMP(a_touch_needs_crc, clk, rst, out_valid && !crc_ok, !touch_down, "bad CRC touch")

endmodule

[sim/tb_single_wire_panel_session_engine.sv]
module tb_single_wire_panel_session_engine;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int ITEM_TARGET = 650;

  typedef enum int {PANEL_KEY, PANEL_TOUCH, PANEL_SILENT} panel_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        line_in = 1'b1;
  logic        bl_req_valid = 1'b0;
  logic [6:0]  bl_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        line_out;
  logic        line_drive;
  logic        done_valid;
  logic        crc_ok;
  logic [2:0]  request_kind;
  logic [7:0]  data0;
  logic [7:0]  data1;
  logic [7:0]  data2;
  logic [11:0] touch_x;
  logic [11:0] touch_y;
  logic        touch_down;
  logic        panel_absent;

  single_wire_panel_session_engine dut (.*);

  initial forever #5 clk = ~clk;

  // Mirror of the link master: configuration and session state.
  logic [23:0]       bit_per = swpse_pkg::BIT_PERIOD_RESET;
  logic [23:0]       poll_per = swpse_pkg::POLL_PERIOD_RESET;
  logic              touch_cap = 1'b1;
  swpse_pkg::phase_t ph = swpse_pkg::PH_IDLE;
  logic [5:0]        bit_cnt = '0;
  logic [31:0]       shreg = '0;
  logic [7:0]        req_byte = '0;
  logic [23:0]       wait_cnt = '0;
  logic [7:0]        ptype = '0;
  logic              absent = 1'b0;
  logic              bl_init = 1'b0;
  logic              key_en = 1'b0;
  logic              touch_en = 1'b0;
  logic [7:0]        pend_lvl = '0;
  logic [4:0]        sess_cnt = '0;
  logic              wire_lvl = 1'b1;
  logic              wire_drv = 1'b1;

  swpse_pkg::result_t link_results_due[$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 items_sent = 0;

  // Stimulus policy, changed by the test tasks.
  panel_style_t panel_style;
  logic [7:0]   discovered_type;
  int           unknown_sessions = 15;
  int           bad_answer_pct = 0;
  int           bl_post_pct = 0;
  bit           post_at_idle = 1'b0;
  bit           idle_on = 1'b0;
  bit           hold_go = 1'b0;
  int           hold_cycles = 0;
  logic [31:0]  panel_answer = '0;
  bit           answer_ready = 1'b0;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ swpse_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [23:0] reload_of(logic [23:0] period);
    return (period == 24'd0) ? 24'd0 : period - 24'd1;
  endfunction

  function automatic swpse_pkg::result_t predict_link_tick(logic li, logic bv, logic [6:0] lv);
    swpse_pkg::result_t r;
    logic [7:0]  req, b0, b1, b2, b3;
    logic [11:0] x, y;
    bit          have;
    r = '0;
    if (bv && bl_init) pend_lvl = 8'h80 + {1'b0, lv};
    if (ph != swpse_pkg::PH_STOPPED) begin
      if (wait_cnt != 24'd0) begin
        wait_cnt = wait_cnt - 24'd1;
      end else begin
        bit_cnt = bit_cnt - 6'd1;
        case (ph)
          swpse_pkg::PH_IDLE: begin
            have = 1'b1;
            req = '0;
            if (ptype == 8'd0) req = swpse_pkg::RQ_INFO;
            else if (!bl_init) req = swpse_pkg::RQ_BLINIT;
            else if (pend_lvl != 8'd0) begin
              req = pend_lvl;
              pend_lvl = '0;
            end
            else if (key_en) req = swpse_pkg::RQ_KEY;
            else if (touch_en) req = swpse_pkg::RQ_TOUCH;
            else have = 1'b0;
            if (have) begin
              req_byte = req;
              shreg = {16'h0, req, crc8_byte(swpse_pkg::CRC_INIT, req)};
              wire_lvl = 1'b0;
              wire_drv = 1'b1;
              bit_cnt = 6'd1;
              ph = swpse_pkg::PH_START;
              wait_cnt = reload_of(bit_per);
            end else begin
              wait_cnt = reload_of(poll_per);
            end
          end
          swpse_pkg::PH_START: begin
            if (bit_cnt == 6'd0) begin
              bit_cnt = swpse_pkg::REQUEST_BITS;
              ph = swpse_pkg::PH_REQUEST;
            end
            wait_cnt = reload_of(bit_per);
          end
          swpse_pkg::PH_REQUEST: begin
            wire_lvl = shreg[bit_cnt[3:0]];
            if (bit_cnt == 6'd0) begin
              bit_cnt = 6'd2;
              ph = swpse_pkg::PH_WAITING;
            end
            wait_cnt = reload_of(bit_per);
          end
          swpse_pkg::PH_WAITING: begin
            if (bit_cnt == 6'd0) begin
              bit_cnt = swpse_pkg::RESPONSE_BITS;
              shreg = '0;
              ph = swpse_pkg::PH_RESPONSE;
            end
            if (bit_cnt == 6'd1) begin
              wire_drv = 1'b0;
              wire_lvl = 1'b1;
            end
            wait_cnt = reload_of(bit_per);
          end
          swpse_pkg::PH_RESPONSE: begin
            if (li) shreg[bit_cnt[4:0]] = 1'b1;
            if (bit_cnt != 6'd0) begin
              wait_cnt = reload_of(bit_per);
            end else begin
              wire_drv = 1'b1;
              wire_lvl = 1'b1;
              ph = swpse_pkg::PH_IDLE;
              {b0, b1, b2, b3} = shreg;
              r.done_valid = 1'b1;
              r.crc_ok = (crc8_byte(crc8_byte(crc8_byte(crc8_byte(swpse_pkg::CRC_INIT, b0), b1),
                                              b2), b3) == 8'd0);
              if (req_byte == swpse_pkg::RQ_INFO) r.request_kind = swpse_pkg::KIND_INFO;
              else if (req_byte == swpse_pkg::RQ_BLINIT) r.request_kind = swpse_pkg::KIND_BLINIT;
              else if (req_byte[7]) r.request_kind = swpse_pkg::KIND_BRIGHT;
              else if (req_byte == swpse_pkg::RQ_KEY) r.request_kind = swpse_pkg::KIND_KEY;
              else r.request_kind = swpse_pkg::KIND_TOUCH;
              r.data0 = b0;
              r.data1 = b1;
              r.data2 = b2;
              if (r.crc_ok) begin
                if (req_byte == swpse_pkg::RQ_INFO) begin
                  if (b0 != swpse_pkg::NO_TYPE) begin
                    ptype = b0;
                    if (b0 == swpse_pkg::KEY_TYPE) key_en = 1'b1;
                    if (touch_cap) touch_en = 1'b1;
                  end
                end else if (req_byte == swpse_pkg::RQ_BLINIT) begin
                  bl_init = 1'b1;
                end else if (req_byte == swpse_pkg::RQ_TOUCH) begin
                  x = {b0[7:4], b1};
                  y = {b0[3:0], b2};
                  r.touch_x = x;
                  r.touch_y = y;
                  r.touch_down = (x != swpse_pkg::COORD_NONE) && (y != swpse_pkg::COORD_NONE);
                end
              end
              if (sess_cnt < swpse_pkg::SESSION_MAX) sess_cnt = sess_cnt + 5'd1;
              if (ptype == 8'd0 && sess_cnt > swpse_pkg::ABSENT_AFTER) begin
                absent = 1'b1;
                ph = swpse_pkg::PH_STOPPED;
              end else begin
                wait_cnt = reload_of(poll_per);
              end
            end
          end
          default: ;
        endcase
      end
    end
    r.line_out = wire_lvl;
    r.line_drive = wire_drv;
    r.panel_absent = absent;
    return r;
  endfunction

  // What the panel answers to the request of the session now in progress.
  function automatic logic [31:0] build_panel_answer();
    logic [7:0]  b0, b1, b2;
    logic [31:0] w;
    bit          corrupt, noise;
    int          pick;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    corrupt = 1'b0;
    noise = 1'b0;
    pick = $urandom_range(0, 99);
    if (req_byte == swpse_pkg::RQ_INFO) begin
      if (sess_cnt < unknown_sessions) begin
        case ($urandom_range(0, 4))
          0: b0 = swpse_pkg::NO_TYPE;
          1: b0 = 8'd0;
          2: begin
            b0 = swpse_pkg::KEY_TYPE;
            corrupt = 1'b1;
          end
          3: noise = 1'b1;
          default: corrupt = 1'b1;
        endcase
      end else begin
        b0 = discovered_type;
      end
    end else begin
      if (req_byte == swpse_pkg::RQ_TOUCH) begin
        case ($urandom_range(0, 5))
          0: begin
            b0[7:4] = 4'hF;
            b1 = 8'hFF;
          end
          1: begin
            b0[3:0] = 4'hF;
            b2 = 8'hFF;
          end
          2: {b0, b1, b2} = 24'hFFFFFF;
          3: {b0, b1, b2} = 24'h0;
          default: ;
        endcase
      end
      if (pick < bad_answer_pct) begin
        if (pick % 2 == 0) corrupt = 1'b1;
        else noise = 1'b1;
      end
    end
    w = {b0, b1, b2, crc8_byte(crc8_byte(crc8_byte(swpse_pkg::CRC_INIT, b0), b1), b2)};
    if (corrupt) w[$urandom_range(0, 31)] ^= 1'b1;
    if (noise) w = $urandom;
    return w;
  endfunction

  task automatic offer_tick(input logic li, input logic bv, input logic [6:0] lv);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_in <= li;
    bl_req_valid <= bv;
    bl_level <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    link_results_due.push_back(predict_link_tick(li, bv, lv));
    items_sent++;
  endtask

  task automatic drive_panel_tick();
    logic       li, bv;
    logic [6:0] lv;
    logic [5:0] bit_idx;
    bit         event_next;
    event_next = (wait_cnt == 24'd0) && (ph != swpse_pkg::PH_STOPPED);
    li = 1'($urandom_range(0, 1));
    if (ph == swpse_pkg::PH_RESPONSE) begin
      if (!answer_ready) begin
        panel_answer = build_panel_answer();
        answer_ready = 1'b1;
      end
      bit_idx = bit_cnt - 6'd1;
      if (event_next) li = panel_answer[bit_idx[4:0]];
    end else begin
      answer_ready = 1'b0;
    end
    bv = ($urandom_range(0, 99) < bl_post_pct);
    // A request posted on the very tick of an idle event must be picked by it.
    if (post_at_idle && event_next && ph == swpse_pkg::PH_IDLE && $urandom_range(0, 1) == 1)
      bv = 1'b1;
    case ($urandom_range(0, 3))
      0: lv = 7'd0;
      1: lv = 7'h7F;
      default: lv = 7'($urandom_range(0, 127));
    endcase
    offer_tick(li, bv, lv);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) drive_panel_tick();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      swpse_pkg::REG_BIT_PERIOD: bit_per = val;
      swpse_pkg::REG_POLL_PERIOD: poll_per = val;
      swpse_pkg::REG_TOUCH_CAPABLE: touch_cap = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_register_setup();
    write_reg(swpse_pkg::REG_BIT_PERIOD, 24'hFFFFFF);
    write_reg(swpse_pkg::REG_POLL_PERIOD, 24'hFFFFFF);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    write_reg(swpse_pkg::REG_TOUCH_CAPABLE, 24'hFFFFFE);
    write_reg(swpse_pkg::REG_BIT_PERIOD, 24'd0);
    write_reg(swpse_pkg::REG_POLL_PERIOD, 24'd2);
    write_reg(swpse_pkg::REG_TOUCH_CAPABLE, (panel_style == PANEL_SILENT) ? 24'd0 : 24'd1);
  endtask

  // Sessions without a usable panel type, at times right up to the absent limit, then a good
  // answer; with give_up set no good answer comes and the panel goes absent.
  task automatic test_panel_discovery(input bit give_up, input int unknown_limit);
    unknown_sessions = give_up ? 32 : unknown_limit;
    idle_on = 1'b1;
    bl_post_pct = 20;
    while (ptype == 8'd0 && !absent) drive_panel_tick();
    if (absent) run_ticks(60);
    drain();
  endtask

  task automatic test_backlight_init();
    bad_answer_pct = 40;
    while (!bl_init && !absent) drive_panel_tick();
    drain();
    write_reg(swpse_pkg::REG_BIT_PERIOD, 24'd1);
    write_reg(swpse_pkg::REG_POLL_PERIOD, 24'd0);
  endtask

  task automatic test_brightness();
    bad_answer_pct = 10;
    bl_post_pct = 8;
    post_at_idle = 1'b1;
    run_ticks(100);
    drain();
  endtask

  task automatic test_session_polling();
    write_reg(swpse_pkg::REG_POLL_PERIOD, 24'd3);
    bad_answer_pct = 20;
    bl_post_pct = 1;
    post_at_idle = 1'b0;
    run_ticks(100);
    drain();
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 250;
    hold_go = 1'b1;
    run_ticks(40);
    drain();
  endtask

  task automatic test_register_sweep();
    write_reg(swpse_pkg::REG_BIT_PERIOD, 24'd3);
    write_reg(swpse_pkg::REG_POLL_PERIOD, 24'd1);
    write_reg(swpse_pkg::REG_TOUCH_CAPABLE, 24'd0);
    run_ticks(50);
    drain();
    write_reg(swpse_pkg::REG_BIT_PERIOD, 24'd2);
    write_reg(swpse_pkg::REG_POLL_PERIOD, 24'd5);
    write_reg(swpse_pkg::REG_TOUCH_CAPABLE, 24'd1);
    run_ticks(40);
    drain();
  endtask

  task automatic test_random_traffic();
    int chunk_len;
    for (int chunk = 0; chunk < 6; chunk++) begin
      idle_on = (chunk < 5) && ($urandom_range(0, 3) != 0);
      write_reg(swpse_pkg::REG_BIT_PERIOD, 24'($urandom_range(0, 3)));
      write_reg(swpse_pkg::REG_POLL_PERIOD, 24'($urandom_range(0, 7)));
      if ($urandom_range(0, 2) == 0)
        write_reg(swpse_pkg::REG_TOUCH_CAPABLE, 24'($urandom_range(0, 1)));
      bad_answer_pct = $urandom_range(0, 40);
      bl_post_pct = $urandom_range(0, 10);
      post_at_idle = 1'($urandom_range(0, 1));
      // The remaining budget is spread over the chunks; the idle-free last one stays long.
      chunk_len = (ITEM_TARGET - items_sent) / (6 - chunk);
      if (chunk_len < 12) chunk_len = 12;
      if (chunk == 5 && chunk_len < 40) chunk_len = 40;
      run_ticks(chunk_len);
      drain();
    end
  endtask

  initial begin : main_sequence
    int discovery_pick;
    case ($urandom_range(0, 9))
      0, 1, 2: panel_style = PANEL_KEY;
      3, 4:    panel_style = PANEL_SILENT;
      default: panel_style = PANEL_TOUCH;
    endcase
    if (panel_style == PANEL_KEY) begin
      discovered_type = swpse_pkg::KEY_TYPE;
    end else begin
      do discovered_type = 8'($urandom_range(1, 254));
      while (discovered_type == swpse_pkg::KEY_TYPE);
    end
    discovery_pick = $urandom_range(0, 15);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_setup();
    test_panel_discovery(discovery_pick == 0, (discovery_pick == 1) ? 15 : 2);
    test_backlight_init();
    test_brightness();
    test_session_polling();
    test_output_backpressure();
    test_register_sweep();
    test_random_traffic();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // The long hold lets the sender keep offering ticks until the block stalls its input.
  initial begin : receiver_side
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_stall <= 1'b1;
        for (int n = 0; n < hold_cycles; n++) @(posedge clk);
        hold_go = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    swpse_pkg::result_t seen, want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = {line_out, line_drive, done_valid, crc_ok, request_kind, data0, data1, data2,
              touch_x, touch_y, touch_down, panel_absent};
      if (link_results_due.size() == 0) begin
        if (mismatches < 10) $display("Result transfer with nothing expected: %h", seen);
        mismatches++;
      end else begin
        want = link_results_due.pop_front();
        if (seen !== want) begin
          if (mismatches < 10) begin
            $display("Tick result mismatch at %0t", $realtime);
            $display("  expected drive %0b out %0b done %0b crc %0b kind %0d data %h %h %h",
                     want.line_drive, want.line_out, want.done_valid, want.crc_ok,
                     want.request_kind, want.data0, want.data1, want.data2);
            $display("           x %h y %h down %0b absent %0b",
                     want.touch_x, want.touch_y, want.touch_down, want.panel_absent);
            $display("  actual   drive %0b out %0b done %0b crc %0b kind %0d data %h %h %h",
                     seen.line_drive, seen.line_out, seen.done_valid, seen.crc_ok,
                     seen.request_kind, seen.data0, seen.data1, seen.data2);
            $display("           x %h y %h down %0b absent %0b",
                     seen.touch_x, seen.touch_y, seen.touch_down, seen.panel_absent);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
